// File: src/dpm_pkg.sv
`default_nettype none

package dpm_pkg;

  localparam int ADDR_W    = 20;
  localparam int PAGE_IN_W = 16;
  localparam int FLAG_W    = 3;
  localparam int CNT_W     = 32;
  localparam int OP_W      = 2;
  localparam int ST_W      = 3;

  // flag bits of a table entry
  localparam int FLAG_WRITE_BIT = 1;
  localparam int FLAG_READ_BIT  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_MAP   = 2'd0,
    OP_UNMAP = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 3'd0,
    ST_RANGE  = 3'd1,
    ST_ABSENT = 3'd2,
    ST_DENIED = 3'd3,
    ST_NOFREE = 3'd4
  } status_e;

  // input word, last field in the lowest bits
  typedef struct packed {
    logic                 pad;
    logic [FLAG_W-1:0]    flags;
    logic [PAGE_IN_W-1:0] map_ppn;
    logic [PAGE_IN_W-1:0] map_vpn;
    logic [ADDR_W-1:0]    virt_addr;
  } in_t;

  // result word, last field in the lowest bits
  typedef struct packed {
    logic [CNT_W-1:0]  fail_count;
    logic [CNT_W-1:0]  write_count;
    logic [CNT_W-1:0]  read_count;
    logic [CNT_W-1:0]  fault_count;
    logic              new_page;
    logic [ADDR_W-1:0] phys_addr;
    status_e           status;
  } res_t;

  localparam int IN_W  = $bits(in_t);
  localparam int OUT_W = $bits(res_t);

endpackage

`default_nettype wire

// File: src/demand_paging_mmu.sv
// demand_paging_mmu: demand-paging translation over a two-level page table.
// Input stream (s_axis): one word per operation. tuser carries the opcode
// (map, unmap, read, write); tdata carries address, pages and map flags.
// Output stream (m_axis): exactly one result word per input word, in order:
// status, physical address, new-page flag and the four running counters.
// An accepted word passes through the input register (with a synchronous table
// read), then through one pass of lookup/fault logic into the result register.
// Throughput: one word per cycle while m_axis_tready is high; the free-page
// search is a single priority encoder over the used-page bitmap, so a fault
// does not slow the stream.
// Reset (rst_ni low, async): all entries invalid, all groups absent, all
// physical pages free, counters zero, both stages empty. No clearing pass.
// Stall: when m_axis_tready is low the result word holds; one more word may
// sit in the input stage, after which s_axis_tready drops. Table updates
// take effect only when a word moves into the result register, so a
// stalled word never changes state twice.
`default_nettype none

module demand_paging_mmu #(
  parameter int VIRT_PAGES  = 256,
  parameter int GROUP_SIZE  = 16,
  parameter int PHYS_PAGES  = 256,
  parameter int OFFSET_BITS = 12
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // tdata: virt_addr[19:0], map_vpn[35:20], map_ppn[51:36], flags[54:52]
  input  wire logic [dpm_pkg::IN_W-1:0]    s_axis_tdata,
  // tuser: operation[1:0]
  input  wire logic [dpm_pkg::OP_W-1:0]    s_axis_tuser,
  input  wire logic                        s_axis_tvalid,
  output      logic                        s_axis_tready,
  // tdata: status[2:0], phys_addr[22:3], new_page[23], fault_count[55:24],
  //        read_count[87:56], write_count[119:88], fail_count[151:120]
  output      logic [dpm_pkg::OUT_W-1:0]   m_axis_tdata,
  output      logic                        m_axis_tvalid,
  input  wire logic                        m_axis_tready
);

  localparam int VPW        = $clog2(VIRT_PAGES);
  localparam int PPW        = $clog2(PHYS_PAGES);
  localparam int NUM_GROUPS = (VIRT_PAGES + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int GW         = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  // group = page / GROUP_SIZE by reciprocal multiply, exact for pages < 2^12
  localparam int GRP_SH     = 24;
  localparam int GRP_M      = ((1 << GRP_SH) + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PROD_W     = VPW + GRP_SH + 1;
  localparam int ENT_W      = PPW + 2;  // page, write, read
  localparam int AW         = dpm_pkg::ADDR_W;
  localparam int CW         = dpm_pkg::CNT_W;

  // ---------------------------------------------------------------- input
  dpm_pkg::in_t in_w;
  logic         s_acc;
  logic         in_is_acc;
  logic [AW-1:0] in_va_pg;
  logic [AW-1:0] in_pg;
  logic [VPW-1:0] rd_idx;
  logic [PROD_W-1:0] grp_prod;

  assign in_w      = s_axis_tdata;
  assign s_acc     = s_axis_tvalid && s_axis_tready;
  assign in_is_acc = (s_axis_tuser == dpm_pkg::OP_READ) ||
                     (s_axis_tuser == dpm_pkg::OP_WRITE);
  assign in_va_pg  = AW'(in_w.virt_addr >> OFFSET_BITS);
  assign in_pg     = in_is_acc ? in_va_pg : AW'(in_w.map_vpn);
  assign rd_idx    = in_pg[VPW-1:0];
  assign grp_prod  = PROD_W'(rd_idx) * PROD_W'(GRP_M);

  // ------------------------------------------------------ stage 1 regs
  logic                    s1_valid_q;
  dpm_pkg::op_e            s1_op_q;
  logic [OFFSET_BITS-1:0]  s1_off_q;
  logic                    s1_vp_oor_q;
  logic                    s1_pp_oor_q;
  logic [VPW-1:0]          s1_idx_q;
  logic [GW-1:0]           s1_grp_q;
  logic [PPW-1:0]          s1_pp_q;
  logic [dpm_pkg::FLAG_W-1:0] s1_flags_q;
  logic [ENT_W-1:0]        ent_rd_q;

  // state
  logic [VIRT_PAGES-1:0]   ent_valid_q, ent_valid_d;
  logic [NUM_GROUPS-1:0]   grp_present_q, grp_present_d;
  logic [PHYS_PAGES-1:0]   used_q, used_d;
  logic [CW-1:0]           fault_cnt_q, fault_cnt_d;
  logic [CW-1:0]           read_cnt_q, read_cnt_d;
  logic [CW-1:0]           write_cnt_q, write_cnt_d;
  logic [CW-1:0]           fail_cnt_q, fail_cnt_d;

  // entry table: page and permission bits; valid bits live in flops
  logic [ENT_W-1:0]        ent_mem [VIRT_PAGES];
  logic                    mem_we;
  logic                    install;
  logic [ENT_W-1:0]        mem_wdata;

  // output stage
  logic                    out_valid_q;
  dpm_pkg::res_t           out_q, res;
  logic                    s1_adv;

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign mem_we        = s1_adv && install;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_op_q     <= dpm_pkg::op_e'(s_axis_tuser);
      s1_off_q    <= in_w.virt_addr[OFFSET_BITS-1:0];
      s1_vp_oor_q <= in_pg >= AW'(VIRT_PAGES);
      s1_pp_oor_q <= in_w.map_ppn >= dpm_pkg::PAGE_IN_W'(PHYS_PAGES);
      s1_idx_q    <= rd_idx;
      s1_grp_q    <= grp_prod[GRP_SH +: GW];
      s1_pp_q     <= in_w.map_ppn[PPW-1:0];
      s1_flags_q  <= in_w.flags;
    end
  end

  // table write from stage 1, read for the incoming word with bypass
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ent_mem[s1_idx_q] <= mem_wdata;
    end
    if (s_acc) begin
      ent_rd_q <= (mem_we && (s1_idx_q == rd_idx)) ? mem_wdata : ent_mem[rd_idx];
    end
  end

  // ------------------------------------------------ free-page search
  logic [PHYS_PAGES-1:0] free_oh;
  logic [PPW-1:0]        free_idx;
  logic                  free_found;

  assign free_oh    = ~used_q & (used_q + PHYS_PAGES'(1));
  assign free_found = ~&used_q;

  always_comb begin
    free_idx = '0;
    for (int i = 0; i < PHYS_PAGES; i++) begin
      if (free_oh[i]) free_idx = free_idx | PPW'(i);
    end
  end

  // ------------------------------------------------- lookup and update
  logic [PPW-1:0] ent_page;
  logic           ent_w, ent_r, ent_v, grp_v, is_wr, perm_ok;

  assign ent_page = ent_rd_q[ENT_W-1:2];
  assign ent_w    = ent_rd_q[1];
  assign ent_r    = ent_rd_q[0];
  assign ent_v    = ent_valid_q[s1_idx_q];
  assign grp_v    = grp_present_q[s1_grp_q];
  assign is_wr    = (s1_op_q == dpm_pkg::OP_WRITE);
  assign perm_ok  = is_wr ? ent_w : ent_r;

  always_comb begin
    ent_valid_d   = ent_valid_q;
    grp_present_d = grp_present_q;
    used_d        = used_q;
    fault_cnt_d   = fault_cnt_q;
    read_cnt_d    = read_cnt_q;
    write_cnt_d   = write_cnt_q;
    fail_cnt_d    = fail_cnt_q;
    install       = 1'b0;
    mem_wdata     = {s1_pp_q, s1_flags_q[dpm_pkg::FLAG_WRITE_BIT],
                     s1_flags_q[dpm_pkg::FLAG_READ_BIT]};
    res.status    = dpm_pkg::ST_OK;
    res.new_page  = 1'b0;
    res.phys_addr = '0;

    unique case (s1_op_q)
      dpm_pkg::OP_MAP: begin
        if (s1_vp_oor_q || s1_pp_oor_q) begin
          res.status = dpm_pkg::ST_RANGE;
        end else begin
          install                 = 1'b1;
          ent_valid_d[s1_idx_q]   = 1'b1;
          grp_present_d[s1_grp_q] = 1'b1;
          used_d[s1_pp_q]         = 1'b1;
        end
      end
      dpm_pkg::OP_UNMAP: begin
        if (s1_vp_oor_q) begin
          res.status = dpm_pkg::ST_RANGE;
        end else if (!grp_v) begin
          res.status = dpm_pkg::ST_ABSENT;
        end else begin
          if (ent_v) used_d[ent_page] = 1'b0;
          ent_valid_d[s1_idx_q] = 1'b0;
        end
      end
      dpm_pkg::OP_READ, dpm_pkg::OP_WRITE: begin
        if (s1_vp_oor_q) begin
          fail_cnt_d = fail_cnt_q + CW'(1);
          res.status = dpm_pkg::ST_RANGE;
        end else if (!grp_v || !ent_v) begin
          // page fault: grab lowest free page, map read-write, retry hits
          fail_cnt_d  = fail_cnt_q + CW'(1);
          fault_cnt_d = fault_cnt_q + CW'(1);
          if (!free_found) begin
            res.status = dpm_pkg::ST_NOFREE;
          end else begin
            install                 = 1'b1;
            mem_wdata               = {free_idx, 1'b1, 1'b1};
            ent_valid_d[s1_idx_q]   = 1'b1;
            grp_present_d[s1_grp_q] = 1'b1;
            used_d[free_idx]        = 1'b1;
            res.new_page            = 1'b1;
            res.phys_addr           = AW'({free_idx, s1_off_q});
            if (is_wr) write_cnt_d = write_cnt_q + CW'(1);
            else       read_cnt_d  = read_cnt_q + CW'(1);
          end
        end else if (!perm_ok) begin
          fail_cnt_d = fail_cnt_q + CW'(1);
          res.status = dpm_pkg::ST_DENIED;
        end else begin
          res.phys_addr = AW'({ent_page, s1_off_q});
          if (is_wr) write_cnt_d = write_cnt_q + CW'(1);
          else       read_cnt_d  = read_cnt_q + CW'(1);
        end
      end
    endcase

    res.fault_count = fault_cnt_d;
    res.read_count  = read_cnt_d;
    res.write_count = write_cnt_d;
    res.fail_count  = fail_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q   <= '0;
      grp_present_q <= '0;
      used_q        <= '0;
      fault_cnt_q   <= '0;
      read_cnt_q    <= '0;
      write_cnt_q   <= '0;
      fail_cnt_q    <= '0;
    end else if (s1_adv) begin
      ent_valid_q   <= ent_valid_d;
      grp_present_q <= grp_present_d;
      used_q        <= used_d;
      fault_cnt_q   <= fault_cnt_d;
      read_cnt_q    <= read_cnt_d;
      write_cnt_q   <= write_cnt_d;
      fail_cnt_q    <= fail_cnt_d;
    end
  end

  // ------------------------------------------------------ result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

// File: src/dpm_checker.sv
`default_nettype none

module dpm_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic [dpm_pkg::IN_W-1:0]  s_axis_tdata,
  input wire logic [dpm_pkg::OP_W-1:0]  s_axis_tuser,
  input wire logic                      s_axis_tvalid,
  input wire logic                      s_axis_tready,
  input wire logic [dpm_pkg::OUT_W-1:0] m_axis_tdata,
  input wire logic                      m_axis_tvalid,
  input wire logic                      m_axis_tready
);

  dpm_pkg::res_t r;
  logic          in_seen;

  assign r       = m_axis_tdata;
  assign in_seen = s_axis_tvalid && s_axis_tready && (s_axis_tuser != '1 || |s_axis_tdata
                   || !(|s_axis_tdata));

  // stalled word stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word dropped or changed under stall");

  // a fresh page only comes with a successful access
  a_new_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && r.new_page |-> r.status == dpm_pkg::ST_OK)
    else $error("new page flagged on a failed access");

  // no address unless translation succeeded
  a_pa_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && r.status != dpm_pkg::ST_OK |-> r.phys_addr == '0)
    else $error("address given on failure");

  // consecutive results: failures grow by at most one per word
  a_fail_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready) ##1 m_axis_tvalid |->
      dpm_pkg::CNT_W'(r.fail_count - $past(r.fail_count)) <= dpm_pkg::CNT_W'(1))
    else $error("failure count jumped");

  // a result word is withdrawn only after it was taken or an input word was accepted
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(m_axis_tvalid) |-> $past(m_axis_tready) || $past(in_seen))
    else $error("result withdrawn without being taken");

endmodule

bind demand_paging_mmu dpm_checker u_dpm_checker (.*);

`default_nettype wire

// File: tb/demand_paging_mmu_tb.sv
module demand_paging_mmu_tb;

  localparam int VIRT_PAGES     = 256;
  localparam int GROUP_SIZE     = 16;
  localparam int PHYS_PAGES     = 256;
  localparam int OFFSET_BITS    = 12;
  localparam int FLAG_VALID_BIT = 0;

  typedef struct {
    dpm_pkg::op_e op;
    dpm_pkg::in_t word;
  } mmu_req_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  dpm_pkg::in_t               s_word   = '0;
  dpm_pkg::op_e               s_op     = dpm_pkg::OP_MAP;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [dpm_pkg::OUT_W-1:0]  m_word;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;

  demand_paging_mmu u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tdata  (s_word),
    .s_axis_tuser  (s_op),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .m_axis_tdata  (m_word),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Shadow copy of the translation tables and counters.
  logic [7:0]  pte_page    [VIRT_PAGES];
  logic [2:0]  pte_flags   [VIRT_PAGES];
  logic        grp_present [VIRT_PAGES/GROUP_SIZE];
  logic        phys_used   [PHYS_PAGES];
  logic [31:0] n_fault, n_read, n_write, n_fail;

  mmu_req_t      pending_words[$];
  dpm_pkg::res_t results_due[$];
  int            src_idle_pct  = 0;
  int            snk_stall_pct = 0;
  logic          in_taken      = 1'b0;
  int            err_count     = 0;
  int            word_count    = 0;

  function automatic void set_entry(int vp, int pp, logic [2:0] fl);
    pte_page[vp]             = pp[7:0];
    pte_flags[vp]            = fl;
    pte_flags[vp][FLAG_VALID_BIT] = 1'b1;
    grp_present[vp / GROUP_SIZE] = 1'b1;
    phys_used[pp]            = 1'b1;
  endfunction

  // Expected result word for one accepted request; updates the shadow state.
  function automatic dpm_pkg::res_t translate(dpm_pkg::op_e op, dpm_pkg::in_t w);
    dpm_pkg::res_t    r;
    int               vp;
    int               free_pg;
    logic [OFFSET_BITS-1:0] off;
    logic             wr;
    logic             hit;
    logic             allowed;
    r        = '0;
    r.status = dpm_pkg::ST_OK;
    case (op)
      dpm_pkg::OP_MAP: begin
        if (w.map_vpn >= VIRT_PAGES || w.map_ppn >= PHYS_PAGES) begin
          r.status = dpm_pkg::ST_RANGE;
        end else begin
          set_entry(int'(w.map_vpn), int'(w.map_ppn), w.flags);
        end
      end
      dpm_pkg::OP_UNMAP: begin
        vp = int'(w.map_vpn);
        if (w.map_vpn >= VIRT_PAGES) begin
          r.status = dpm_pkg::ST_RANGE;
        end else if (!grp_present[vp / GROUP_SIZE]) begin
          r.status = dpm_pkg::ST_ABSENT;
        end else begin
          // frees the page even when another virtual page still points at it
          if (pte_flags[vp][FLAG_VALID_BIT]) phys_used[pte_page[vp]] = 1'b0;
          pte_page[vp]  = '0;
          pte_flags[vp] = '0;
        end
      end
      default: begin
        wr  = (op == dpm_pkg::OP_WRITE);
        vp  = int'(w.virt_addr[dpm_pkg::ADDR_W-1:OFFSET_BITS]);
        off = w.virt_addr[OFFSET_BITS-1:0];
        hit = grp_present[vp / GROUP_SIZE] && pte_flags[vp][FLAG_VALID_BIT];
        if (!hit) begin
          // page fault: first try fails, then grab the lowest free page
          n_fail++;
          n_fault++;
          free_pg = PHYS_PAGES;
          for (int i = PHYS_PAGES - 1; i >= 0; i--) begin
            if (!phys_used[i]) free_pg = i;
          end
          if (free_pg == PHYS_PAGES) begin
            r.status = dpm_pkg::ST_NOFREE;
          end else begin
            set_entry(vp, free_pg, 3'((1 << dpm_pkg::FLAG_READ_BIT) |
                                      (1 << dpm_pkg::FLAG_WRITE_BIT)));
            r.new_page = 1'b1;
          end
        end
        if (r.status == dpm_pkg::ST_OK) begin
          allowed = wr ? pte_flags[vp][dpm_pkg::FLAG_WRITE_BIT]
                       : pte_flags[vp][dpm_pkg::FLAG_READ_BIT];
          if (!allowed) begin
            n_fail++;
            r.status   = dpm_pkg::ST_DENIED;
            r.new_page = 1'b0;
          end else begin
            r.phys_addr = {pte_page[vp], off};
            if (wr) n_write++;
            else n_read++;
          end
        end
      end
    endcase
    r.fault_count = n_fault;
    r.read_count  = n_read;
    r.write_count = n_write;
    r.fail_count  = n_fail;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR: result word %0d: %s", word_count, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  task automatic queue_req(input dpm_pkg::op_e op, input logic [19:0] va,
                           input logic [15:0] vp, input logic [15:0] pp,
                           input logic [2:0] fl);
    mmu_req_t q;
    q.op             = op;
    q.word           = '0;
    q.word.virt_addr = va;
    q.word.map_vpn   = vp;
    q.word.map_ppn   = pp;
    q.word.flags     = fl;
    pending_words.push_back(q);
  endtask

  // Random request; unused fields carry noise, accesses favor a small window
  // of pages so hits, denials and faults all show up.
  task automatic queue_random_req();
    int           sel;
    logic [19:0]  va;
    logic [15:0]  vp;
    logic [15:0]  pp;
    dpm_pkg::op_e op;
    sel = $urandom_range(0, 99);
    va  = 20'($urandom());
    if ($urandom_range(0, 1) == 1) va[19:12] = 8'($urandom_range(0, 31));
    vp = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 255));
    pp = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 255));
    if (sel < 25)      op = dpm_pkg::OP_MAP;
    else if (sel < 35) op = dpm_pkg::OP_UNMAP;
    else if (sel < 65) op = dpm_pkg::OP_READ;
    else               op = dpm_pkg::OP_WRITE;
    queue_req(op, va, vp, pp, 3'($urandom_range(0, 7)));
  endtask

  // Driver: a new word goes out only once the held one has been taken.
  always @(negedge clk) begin : drive_words
    mmu_req_t nxt;
    logic     go;
    if (rst_n && (!s_tvalid || in_taken)) begin
      go = (pending_words.size() != 0) && ($urandom_range(0, 99) >= src_idle_pct);
      if (go) begin
        nxt = pending_words.pop_front();
        s_word <= nxt.word;
        s_op   <= nxt.op;
      end
      s_tvalid <= go;
    end
    m_tready <= rst_n && ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // Monitor: predict on input handshake, check on output handshake.
  always @(posedge clk) begin : watch_words
    dpm_pkg::res_t got;
    dpm_pkg::res_t want;
    in_taken <= s_tvalid && s_tready;
    if (rst_n && s_tvalid && s_tready) begin
      results_due.push_back(translate(s_op, s_word));
    end
    if (rst_n && m_tvalid && m_tready) begin
      got = m_word;
      if (results_due.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = results_due.pop_front();
        check_field("status",      32'(got.status),    32'(want.status));
        check_field("phys_addr",   32'(got.phys_addr), 32'(want.phys_addr));
        check_field("new_page",    32'(got.new_page),  32'(want.new_page));
        check_field("fault_count", got.fault_count,    want.fault_count);
        check_field("read_count",  got.read_count,     want.read_count);
        check_field("write_count", got.write_count,    want.write_count);
        check_field("fail_count",  got.fail_count,     want.fail_count);
      end
      word_count++;
    end
  end

  initial begin
    for (int i = 0; i < VIRT_PAGES; i++) begin
      pte_page[i]  = '0;
      pte_flags[i] = '0;
    end
    for (int i = 0; i < VIRT_PAGES / GROUP_SIZE; i++) grp_present[i] = 1'b0;
    for (int i = 0; i < PHYS_PAGES; i++) phys_used[i] = 1'b0;
    n_fault = '0;
    n_read  = '0;
    n_write = '0;
    n_fail  = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: faults, denials, range errors, absent group, unmap cases.
    queue_req(dpm_pkg::OP_READ,  20'h00000, 16'h0000, 16'h0000, 3'b000); // fault, page 0
    queue_req(dpm_pkg::OP_WRITE, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 3'b111); // fault, page 1
    queue_req(dpm_pkg::OP_MAP,   20'h00000, 16'd0,    16'd255,  3'b001); // no r/w rights
    queue_req(dpm_pkg::OP_READ,  20'h00ABC, 16'h0000, 16'h0000, 3'b000); // denied
    queue_req(dpm_pkg::OP_WRITE, 20'h00123, 16'h0000, 16'h0000, 3'b000); // denied
    queue_req(dpm_pkg::OP_MAP,   20'h00000, 16'd1,    16'd2,    3'b100); // read only
    queue_req(dpm_pkg::OP_READ,  20'h01FFF, 16'h0000, 16'h0000, 3'b000);
    queue_req(dpm_pkg::OP_WRITE, 20'h01000, 16'h0000, 16'h0000, 3'b000); // denied
    queue_req(dpm_pkg::OP_MAP,   20'h00000, 16'd2,    16'd3,    3'b010); // write only
    queue_req(dpm_pkg::OP_WRITE, 20'h02555, 16'h0000, 16'h0000, 3'b000);
    queue_req(dpm_pkg::OP_READ,  20'h02555, 16'h0000, 16'h0000, 3'b000); // denied
    queue_req(dpm_pkg::OP_MAP,   20'h00000, 16'd256,  16'd5,    3'b111); // virt range
    queue_req(dpm_pkg::OP_MAP,   20'h00000, 16'd3,    16'd256,  3'b111); // phys range
    queue_req(dpm_pkg::OP_MAP,   20'hFFFFF, 16'hFFFF, 16'hFFFF, 3'b111);
    queue_req(dpm_pkg::OP_UNMAP, 20'h00000, 16'hFFFF, 16'h0000, 3'b000); // range
    queue_req(dpm_pkg::OP_UNMAP, 20'h00000, 16'd256,  16'h0000, 3'b000); // range
    queue_req(dpm_pkg::OP_UNMAP, 20'h00000, 16'h0020, 16'h0000, 3'b000); // group absent
    queue_req(dpm_pkg::OP_UNMAP, 20'h00000, 16'd0,    16'h0000, 3'b000); // frees 255
    queue_req(dpm_pkg::OP_UNMAP, 20'h00000, 16'd5,    16'h0000, 3'b000); // invalid entry
    queue_req(dpm_pkg::OP_READ,  20'h00000, 16'h0000, 16'h0000, 3'b000); // lowest free
    queue_req(dpm_pkg::OP_MAP,   20'h00000, 16'd4,    16'd3,    3'b111); // shares page 3
    queue_req(dpm_pkg::OP_UNMAP, 20'h00000, 16'd4,    16'h0000, 3'b000); // frees shared
    queue_req(dpm_pkg::OP_READ,  20'h30000, 16'h0000, 16'h0000, 3'b000); // absent group
    queue_req(dpm_pkg::OP_MAP,   20'h00000, 16'd255,  16'd0,    3'b110);
    queue_req(dpm_pkg::OP_READ,  20'hFF000, 16'h0000, 16'h0000, 3'b000);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 70; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 70; end
        default: begin src_idle_pct = 31; snk_stall_pct = 31; end
      endcase
      // every physical page put in use, so faults report no free page until unmaps free some
      if (ph == 1) begin
        for (int k = 0; k < PHYS_PAGES; k++) begin
          queue_req(dpm_pkg::OP_MAP, 20'($urandom()), 16'($urandom_range(0, 255)),
                    16'(k), 3'($urandom_range(0, 7)));
        end
      end
      for (int n = 0; n < 170; n++) queue_random_req();
      // the next phase waits until the block has drained
      while (pending_words.size() != 0 || s_tvalid || results_due.size() != 0) begin
        @(posedge clk);
      end
    end

    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: demand_paging_mmu.f
src/dpm_pkg.sv
src/demand_paging_mmu.sv
src/dpm_checker.sv
tb/demand_paging_mmu_tb.sv
